// ----- rtl/gprq_pkg.sv -----
// Shared types and constants for the grid point radius query block.
// No dependencies.
package gprq_pkg;

    localparam int CoordW = 32;
    localparam int SumW   = 33;
    localparam int CellW  = 31;
    localparam int MaxW   = 20;
    localparam int QnW    = 16;
    localparam int PnW    = 6;
    localparam int StW    = 2;
    localparam int OpW    = 2;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 31;
    // quotient of a 34-bit signed edge by a cell size of at least 1
    localparam int QuoW   = 34;

    typedef enum logic [OpW-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [StW-1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [CfgIdxW-1:0] CFG_CELL_SIZE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_CELLS = 1'd1;

    typedef struct packed {
        logic                     start;
        logic signed [QuoW-1:0]   dividend;
        logic [CellW-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [QuoW-1:0]   quotient;
    } div_rsp_t;

endpackage

// ----- rtl/gprq_floor_div.sv -----
// Bit-serial signed floor divider: one quotient bit per cycle.
// Depends on gprq_pkg.
module gprq_floor_div
    import gprq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CntW = $clog2(QuoW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [QuoW-1:0]   num_reg, num_next;      // magnitude, shifted out
    logic [QuoW-1:0]   quo_reg, quo_next;
    logic [CellW:0]    rem_reg, rem_next;
    logic [CellW-1:0]  dvs_reg, dvs_next;
    logic [CellW+1:0]  trial;
    logic [CellW:0]    shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[CellW-1:0], num_reg[QuoW-1]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            neg_next  = req.dividend[QuoW-1];
            num_next  = req.dividend[QuoW-1] ? QuoW'(-req.dividend) : QuoW'(req.dividend);
            dvs_next  = (req.divisor == '0) ? CellW'(1) : req.divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CntW'(QuoW);
        end else if (busy_reg) begin
            num_next = {num_reg[QuoW-2:0], 1'b0};
            if (!trial[CellW+1]) begin
                rem_next = trial[CellW:0];
                quo_next = {quo_reg[QuoW-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[QuoW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // floor for negative dividends: -(q) or -(q+1)
                if (neg_reg) begin
                    if ((!trial[CellW+1] ? trial[CellW:0] : shifted) != '0)
                        quo_next = ~quo_next;
                    else
                        quo_next = -quo_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = $signed(quo_reg);

endmodule

// ----- rtl/grid_point_radius_query.sv -----
// Top level of the grid point radius query block.
// Depends on gprq_pkg and gprq_floor_div.
//
// Stores up to POINTS box centres as exact sums min+max in two synchronous
// memories and answers square range queries with a full scan in ascending
// point order, one result transaction per match (or one when none match).
// Clear, add and unused operations need no further states. Their result is
// registered and appears the cycle after acceptance, and the next input
// transaction is taken in the same cycle that the result is accepted.
// A query runs four serial floor divisions for the cell span check. Each
// division is a start step, the 34 quotient bits and a done step. The span
// check follows. The scan then reads each loaded point and tests it, with
// a further step for each match, and a final step issues the last result.
// The serial divider and the single read port of the centre memories set
// the query time, which output stalls lengthen. Each match is held back by
// one step so that last can be set on the final one. There is no clearing
// pass: presence bits live in flip-flops and are cleared at once.
// Configuration writes are taken at any time but must only be issued
// while the block is idle.
module grid_point_radius_query
    import gprq_pkg::*;
#(
    parameter int POINTS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OpW-1:0]             s_operation,
    input  logic signed [CoordW-1:0]   s_box_min_x,
    input  logic signed [CoordW-1:0]   s_box_min_y,
    input  logic signed [CoordW-1:0]   s_box_max_x,
    input  logic signed [CoordW-1:0]   s_box_max_y,
    input  logic signed [CoordW-1:0]   s_query_x,
    input  logic signed [CoordW-1:0]   s_query_y,
    input  logic signed [CoordW-1:0]   s_query_radius,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [StW-1:0]             m_status,
    output logic                       m_match_valid,
    output logic [QnW-1:0]             m_query_number,
    output logic [PnW-1:0]             m_point_number,
    output logic                       m_last
);

    localparam int IdxW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CntW = $clog2(POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_TEST  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CellW-1:0] cell_size_reg;
    logic [MaxW-1:0]  max_cells_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= CellW'(65536);
            max_cells_reg <= MaxW'(1000000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CELL_SIZE: cell_size_reg <= cfg_data[CellW-1:0];
                CFG_MAX_CELLS: max_cells_reg <= cfg_data[MaxW-1:0];
                default: ;
            endcase
        end
    end

    // centre memories, one read port each, registered read data
    logic signed [SumW-1:0] mem_x [POINTS];
    logic signed [SumW-1:0] mem_y [POINTS];
    logic signed [SumW-1:0] rd_x_reg, rd_y_reg;
    logic                   mem_we;
    logic [IdxW-1:0]        mem_waddr, mem_raddr;
    logic signed [SumW-1:0] wr_x, wr_y;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_x[mem_waddr] <= wr_x;
            mem_y[mem_waddr] <= wr_y;
        end
        rd_x_reg <= mem_x[mem_raddr];
        rd_y_reg <= mem_y[mem_raddr];
    end

    logic [POINTS-1:0] present_reg, present_next;
    logic [CntW-1:0]   loaded_reg, loaded_next;
    logic [QnW-1:0]    queries_reg, queries_next;

    // query working registers
    logic signed [SumW:0]   lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;   // doubled bounds
    logic signed [SumW:0]   lo_x_next, hi_x_next, lo_y_next, hi_y_next;
    logic signed [QuoW-1:0] q_reg [4];
    logic [1:0]             div_sel_reg, div_sel_next;
    logic [QnW-1:0]         qn_reg, qn_next;
    logic [CntW-1:0]        scan_reg, scan_next;
    logic [IdxW-1:0]        test_idx_reg, test_idx_next;
    logic                   found_reg, found_next;     // a match is pending
    logic [PnW-1:0]         pend_pn_reg, pend_pn_next;

    // output register
    logic             ov_reg, ov_next;
    logic [StW-1:0]   ost_reg, ost_next;
    logic             omv_reg, omv_next;
    logic             olast_reg, olast_next;
    logic [QnW-1:0]   oqn_reg, oqn_next;
    logic [PnW-1:0]   opn_reg, opn_next;

    div_req_t dreq;
    div_rsp_t drsp;

    gprq_floor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    logic signed [QuoW-1:0] edge_val;
    always_comb begin
        case (div_sel_reg)
            2'd0:    edge_val = QuoW'(hi_x_reg >>> 1);
            2'd1:    edge_val = QuoW'(lo_x_reg >>> 1);
            2'd2:    edge_val = QuoW'(hi_y_reg >>> 1);
            default: edge_val = QuoW'(lo_y_reg >>> 1);
        endcase
    end

    // span check: width, height, product
    logic signed [QuoW:0] span_w, span_h;
    logic [2*MaxW-1:0]    span_prod;
    logic                 span_ok;
    always_comb begin
        span_w = (QuoW+1)'(q_reg[0]) - (QuoW+1)'(q_reg[1]) + (QuoW+1)'(1);
        span_h = (QuoW+1)'(q_reg[2]) - (QuoW+1)'(q_reg[3]) + (QuoW+1)'(1);
        span_ok = (span_w > 0) && (span_h > 0)
               && (span_w <= $signed({1'b0, max_cells_reg}))
               && (span_h <= $signed({1'b0, max_cells_reg}));
        span_prod = span_w[MaxW-1:0] * span_h[MaxW-1:0];
        span_ok = span_ok && (span_prod <= {{MaxW{1'b0}}, max_cells_reg});
    end

    logic s_fire, m_fire, out_free;
    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;

    logic signed [SumW-1:0] add_sx, add_sy;
    logic signed [SumW:0]   ext_x, ext_y, ext_r;
    logic                   add_inv;
    assign add_sx  = SumW'(s_box_min_x) + SumW'(s_box_max_x);
    assign add_sy  = SumW'(s_box_min_y) + SumW'(s_box_max_y);
    assign ext_x   = (SumW+1)'(s_query_x);
    assign ext_y   = (SumW+1)'(s_query_y);
    assign ext_r   = (SumW+1)'(s_query_radius);
    assign add_inv = (s_box_min_x > s_box_max_x) || (s_box_min_y > s_box_max_y);

    logic scan_more, hit;
    assign scan_more = (scan_reg < loaded_reg) && (scan_reg < CntW'(POINTS));
    assign hit = ($signed({rd_x_reg[SumW-1], rd_x_reg}) >= lo_x_reg)
              && ($signed({rd_x_reg[SumW-1], rd_x_reg}) <= hi_x_reg)
              && ($signed({rd_y_reg[SumW-1], rd_y_reg}) >= lo_y_reg)
              && ($signed({rd_y_reg[SumW-1], rd_y_reg}) <= hi_y_reg);

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = loaded_reg[IdxW-1:0];
        wr_x       = add_sx;
        wr_y       = add_sy;
        mem_raddr  = scan_reg[IdxW-1:0];
        state_next = state_reg;
        dreq.start    = 1'b0;
        dreq.dividend = edge_val;
        dreq.divisor  = cell_size_reg;
        if (s_fire && (op_t'(s_operation) == OP_ADD) && (loaded_reg < CntW'(POINTS))
            && !add_inv)
            mem_we = 1'b1;
        unique case (state_reg)
            S_IDLE: if (s_fire && op_t'(s_operation) == OP_QUERY
                        && !s_query_radius[CoordW-1]) state_next = S_DIV;
            S_DIV: begin
                dreq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: if (drsp.done) state_next = (div_sel_reg == 2'd3) ? S_CHECK : S_DIV;
            S_CHECK: if (out_free) state_next = span_ok ? S_SCAN : S_IDLE;
            S_SCAN: if (out_free) state_next = scan_more ? S_TEST : S_IDLE;
            S_TEST: state_next = hit && present_reg[test_idx_reg] ? S_OUT : S_SCAN;
            S_OUT: if (out_free) state_next = S_SCAN;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        present_next  = present_reg;
        loaded_next   = loaded_reg;
        queries_next  = queries_reg;
        lo_x_next     = lo_x_reg;
        hi_x_next     = hi_x_reg;
        lo_y_next     = lo_y_reg;
        hi_y_next     = hi_y_reg;
        div_sel_next  = div_sel_reg;
        qn_next       = qn_reg;
        scan_next     = scan_reg;
        test_idx_next = test_idx_reg;
        found_next    = found_reg;
        pend_pn_next  = pend_pn_reg;
        ov_next       = ov_reg;
        ost_next      = ost_reg;
        omv_next      = omv_reg;
        olast_next    = olast_reg;
        oqn_next      = oqn_reg;
        opn_next      = opn_reg;
        if (m_fire) ov_next = 1'b0;
        if (s_fire) begin
            ov_next    = 1'b1;
            olast_next = 1'b1;
            omv_next   = 1'b0;
            ost_next   = ST_OK;
            oqn_next   = queries_reg;
            opn_next   = '0;
            case (op_t'(s_operation))
                OP_CLEAR: begin
                    present_next = '0;
                    loaded_next  = '0;
                    queries_next = '0;
                    oqn_next     = '0;
                end
                OP_ADD: begin
                    if (loaded_reg >= CntW'(POINTS)) begin
                        ost_next = ST_RANGE;
                    end else begin
                        loaded_next = loaded_reg + CntW'(1);
                        opn_next    = PnW'(loaded_reg);
                        if (add_inv)
                            ost_next = ST_RANGE;
                        else
                            present_next[loaded_reg[IdxW-1:0]] = 1'b1;
                    end
                end
                OP_QUERY: begin
                    queries_next = queries_reg + QnW'(1);
                    qn_next      = queries_reg;
                    lo_x_next    = (ext_x - ext_r) <<< 1;
                    hi_x_next    = (ext_x + ext_r) <<< 1;
                    lo_y_next    = (ext_y - ext_r) <<< 1;
                    hi_y_next    = (ext_y + ext_r) <<< 1;
                    div_sel_next = 2'd0;
                    scan_next    = '0;
                    found_next   = 1'b0;
                    if (s_query_radius[CoordW-1])
                        ost_next = ST_INVAL;
                    else
                        ov_next = 1'b0;   // hold until the span check or the scan decides
                end
                default: oqn_next = '0;
            endcase
        end
        if (state_reg == S_WAIT && drsp.done)
            div_sel_next = div_sel_reg + 2'd1;
        if (state_reg == S_CHECK && out_free && !span_ok) begin
            ov_next = 1'b1; ost_next = ST_RANGE; omv_next = 1'b0;
            oqn_next = qn_reg; opn_next = '0; olast_next = 1'b1;
        end
        if (state_reg == S_SCAN && out_free) begin
            if (scan_more) begin
                test_idx_next = scan_reg[IdxW-1:0];
                scan_next     = scan_reg + CntW'(1);
            end else if (found_reg) begin
                // release the held final match with last set
                ov_next = 1'b1; ost_next = ST_OK; omv_next = 1'b1;
                oqn_next = qn_reg; opn_next = pend_pn_reg; olast_next = 1'b1;
            end else begin
                ov_next = 1'b1; ost_next = ST_OK; omv_next = 1'b0;
                oqn_next = qn_reg; opn_next = '0; olast_next = 1'b1;
            end
        end
        // emit the previously held match, then hold the new one
        if (state_reg == S_OUT && out_free) begin
            if (found_reg) begin
                ov_next = 1'b1; ost_next = ST_OK; omv_next = 1'b1;
                oqn_next = qn_reg; opn_next = pend_pn_reg; olast_next = 1'b0;
            end
            found_next   = 1'b1;
            pend_pn_next = PnW'(test_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            present_reg <= '0;
            loaded_reg  <= '0;
            queries_reg <= '0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            present_reg <= present_next;
            loaded_reg  <= loaded_next;
            queries_reg <= queries_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_x_reg     <= lo_x_next;
        hi_x_reg     <= hi_x_next;
        lo_y_reg     <= lo_y_next;
        hi_y_reg     <= hi_y_next;
        div_sel_reg  <= div_sel_next;
        qn_reg       <= qn_next;
        scan_reg     <= scan_next;
        test_idx_reg <= test_idx_next;
        found_reg    <= found_next;
        pend_pn_reg  <= pend_pn_next;
        ost_reg      <= ost_next;
        omv_reg      <= omv_next;
        olast_reg    <= olast_next;
        oqn_reg      <= oqn_next;
        opn_reg      <= opn_next;
        if (state_reg == S_WAIT && drsp.done)
            q_reg[div_sel_reg] <= drsp.quotient;
    end

    assign m_valid        = ov_reg;
    assign m_status       = ost_reg;
    assign m_match_valid  = omv_reg;
    assign m_query_number = oqn_reg;
    assign m_point_number = opn_reg;
    assign m_last         = olast_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_div_single: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> !drsp.busy)
        else $error("divider restarted while busy");
    a_loaded_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CntW'(POINTS))
        else $error("load count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable({m_status, m_match_valid, m_query_number,
                                           m_point_number, m_last}))
        else $error("result changed while waiting");

endmodule

// ----- tb/tb_grid_point_radius_query.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for grid_point_radius_query: clear, add and query
// transactions checked field by field against an in-bench predictor.
// Depends on gprq_pkg and the block's RTL.
module tb_grid_point_radius_query;
    import gprq_pkg::*;

    localparam int NPTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        op_t              op;
        logic signed [31:0] mnx, mny, mxx, mxy, qx, qy, qr;
    } item_t;

    typedef struct {
        status_t     st;
        logic        mv;
        logic [15:0] qn;
        logic [5:0]  pn;
        logic        lst;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_CELL_SIZE;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OpW-1:0] s_operation = OP_CLEAR;
    logic signed [31:0] s_box_min_x = 0, s_box_min_y = 0, s_box_max_x = 0,
                        s_box_max_y = 0, s_query_x = 0, s_query_y = 0,
                        s_query_radius = 0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [StW-1:0] m_status;
    logic m_match_valid;
    logic [QnW-1:0] m_query_number;
    logic [PnW-1:0] m_point_number;
    logic m_last;

    grid_point_radius_query dut (.*);

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state: our own copy of the store and registers
    logic [30:0] cell_size_q;
    logic [19:0] max_cells_q;
    logic signed [32:0] sum_x [NPTS];
    logic signed [32:0] sum_y [NPTS];
    logic present [NPTS];
    int unsigned loaded;
    logic [15:0] qcount_model;

    item_t   pending_items[$];
    answer_t expected_answers[$];
    int errors = 0;
    int answers_seen = 0;
    int matches_seen = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_off = 1'b0;
    event hold_go;
    int stalled_cycles = 0;

    task automatic report(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic queue_item(input item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic expect_answer(input answer_t a);
        expected_answers.insert(expected_answers.size(), a);
    endtask

    function automatic longint floor_quot(input longint a, input longint c);
        longint q;
        q = a / c;
        if ((a % c) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    function automatic bit span_fits(input longint lx, ly, hx, hy);
        longint c, w, h;
        c = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        w = floor_quot(hx, c) - floor_quot(lx, c) + 1;
        h = floor_quot(hy, c) - floor_quot(ly, c) + 1;
        if (w <= 0 || h <= 0) return 1'b0;
        if (w > longint'(max_cells_q) || h > longint'(max_cells_q)) return 1'b0;
        return (w * h) <= longint'(max_cells_q);
    endfunction

    function automatic answer_t mk(status_t st, logic mv, logic [15:0] qn,
                                   logic [5:0] pn, logic lst);
        answer_t a;
        a.st = st; a.mv = mv; a.qn = qn; a.pn = pn; a.lst = lst;
        return a;
    endfunction

    // Work out the answers of one accepted transaction and advance state.
    task automatic predict_answers(input item_t it);
        longint x, y, r, lx, hx, ly, hy;
        logic [15:0] qn;
        int n;
        case (it.op)
            OP_CLEAR: begin
                foreach (present[i]) present[i] = 1'b0;
                loaded = 0;
                qcount_model = 16'd0;
                expect_answer(mk(ST_OK, 1'b0, 16'd0, 6'd0, 1'b1));
            end
            OP_ADD: begin
                if (loaded >= NPTS) begin
                    expect_answer(mk(ST_RANGE, 1'b0, qcount_model, 6'd0, 1'b1));
                end else if (it.mnx > it.mxx || it.mny > it.mxy) begin
                    present[loaded] = 1'b0;
                    expect_answer(mk(ST_RANGE, 1'b0, qcount_model, 6'(loaded), 1'b1));
                    loaded++;
                end else begin
                    sum_x[loaded] = 33'(it.mnx) + 33'(it.mxx);
                    sum_y[loaded] = 33'(it.mny) + 33'(it.mxy);
                    present[loaded] = 1'b1;
                    expect_answer(mk(ST_OK, 1'b0, qcount_model, 6'(loaded), 1'b1));
                    loaded++;
                end
            end
            OP_QUERY: begin
                x = it.qx; y = it.qy; r = it.qr;
                qn = qcount_model;
                qcount_model = qcount_model + 16'd1;
                if (r < 0) begin
                    expect_answer(mk(ST_INVAL, 1'b0, qn, 6'd0, 1'b1));
                end else begin
                    lx = x - r; hx = x + r; ly = y - r; hy = y + r;
                    if (!span_fits(lx, ly, hx, hy)) begin
                        expect_answer(mk(ST_RANGE, 1'b0, qn, 6'd0, 1'b1));
                    end else begin
                        n = 0;
                        for (int i = 0; i < loaded; i++) begin
                            if (present[i] && longint'(sum_x[i]) >= 2 * lx &&
                                longint'(sum_x[i]) <= 2 * hx &&
                                longint'(sum_y[i]) >= 2 * ly &&
                                longint'(sum_y[i]) <= 2 * hy) begin
                                expect_answer(mk(ST_OK, 1'b1, qn, 6'(i), 1'b0));
                                n++;
                            end
                        end
                        if (n == 0)
                            expect_answer(mk(ST_OK, 1'b0, qn, 6'd0, 1'b1));
                        else
                            expected_answers[$].lst = 1'b1;
                    end
                end
            end
            default: expect_answer(mk(ST_OK, 1'b0, 16'd0, 6'd0, 1'b1));
        endcase
    endtask

    // Driver: hold valid and payload until accepted; insert random gaps.
    always @(posedge aclk) begin
        item_t nxt;
        if (aresetn) begin
            if (s_valid && s_ready) predict_answers(pending_items.pop_front());
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_items[0];
                    s_valid <= 1'b1;
                    s_operation <= nxt.op;
                    s_box_min_x <= nxt.mnx; s_box_min_y <= nxt.mny;
                    s_box_max_x <= nxt.mxx; s_box_max_y <= nxt.mxy;
                    s_query_x <= nxt.qx; s_query_y <= nxt.qy;
                    s_query_radius <= nxt.qr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                answers_seen++;
                if (m_match_valid) matches_seen++;
                if (expected_answers.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    e = expected_answers.pop_front();
                    if (m_status !== e.st)
                        report($sformatf("status %0d, want %0d", m_status, e.st));
                    if (m_match_valid !== e.mv)
                        report($sformatf("match_valid %0b, want %0b", m_match_valid, e.mv));
                    if (m_query_number !== e.qn)
                        report($sformatf("query_number %0d, want %0d",
                                         m_query_number, e.qn));
                    if (m_point_number !== e.pn)
                        report($sformatf("point_number %0d, want %0d",
                                         m_point_number, e.pn));
                    if (m_last !== e.lst)
                        report($sformatf("last %0b, want %0b", m_last, e.lst));
                end
            end
            m_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Receiver hold-off: block results for a long stretch when asked.
    initial forever begin
        @(hold_go);
        hold_off = 1'b1;
        repeat (600) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stalled_cycles <= 0;
        else stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     expected_answers.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic item_t blank(op_t op);
        item_t it;
        it.op = op;
        it.mnx = $urandom; it.mny = $urandom; it.mxx = $urandom; it.mxy = $urandom;
        it.qx = $urandom; it.qy = $urandom; it.qr = $urandom;
        return it;
    endfunction

    function automatic item_t add_box(int cx, int cy, int hw);
        item_t it;
        it = blank(OP_ADD);
        it.mnx = cx - hw; it.mxx = cx + hw;
        it.mny = cy - hw; it.mxy = cy + hw;
        return it;
    endfunction

    function automatic item_t query(int x, int y, int r);
        item_t it;
        it = blank(OP_QUERY);
        it.qx = x; it.qy = y; it.qr = r;
        return it;
    endfunction

    // Random transaction mostly clustered near the origin so queries hit.
    function automatic item_t random_item();
        int sel;
        item_t it;
        sel = $urandom_range(99);
        if (sel < 2) return blank(OP_CLEAR);
        if (sel < 4) return blank(OP_NONE);
        if (sel < 40) begin
            if (sel < 37)
                return add_box($signed($urandom_range(4 << 16)) - (2 << 16),
                               $signed($urandom_range(4 << 16)) - (2 << 16),
                               $urandom_range(1 << 15));
            it = blank(OP_ADD);   // full range, often inverted
            return it;
        end
        if (sel < 90)
            return query($signed($urandom_range(4 << 16)) - (2 << 16),
                         $signed($urandom_range(4 << 16)) - (2 << 16),
                         $urandom_range(3 << 15));
        return blank(OP_QUERY);   // wild values: range refusals, negative radius
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CfgDataW-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_CELL_SIZE) cell_size_q = val[30:0];
        else max_cells_q = val[19:0];
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_answers.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        int pct_s [4] = '{0, 46, 0, 30};
        int pct_r [4] = '{0, 0, 46, 30};
        cell_size_q = 31'd65536;
        max_cells_q = 20'd1000000;
        foreach (present[i]) begin
            present[i] = 1'b0; sum_x[i] = 0; sum_y[i] = 0;
        end
        loaded = 0;
        qcount_model = 16'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every operation, store full, refusals
        write_reg(CFG_MAX_CELLS, 1000000);
        write_reg(CFG_CELL_SIZE, 65536);
        queue_item(blank(OP_CLEAR));
        queue_item(add_box(0, 0, 100));
        queue_item(add_box(32'h7fff_ffff, 32'h8000_0000, 0));
        begin
            item_t it;
            it = blank(OP_ADD);
            it.mnx = 32'h7fff_ffff; it.mxx = 32'h7fff_ffff;
            it.mny = 32'h8000_0000; it.mxy = 32'h8000_0000;
            queue_item(it);
            it.mnx = 5; it.mxx = 4; it.mny = 0; it.mxy = 0;   // inverted box
            queue_item(it);
        end
        queue_item(query(0, 0, 1000));
        queue_item(query(0, 0, -1));
        queue_item(query(0, 0, 32'h8000_0000));
        queue_item(query(0, 0, 32'h7fff_ffff));
        queue_item(query(32'h7fff_ffff, 32'h8000_0000, 65536));
        queue_item(query(0, 0, 0));
        queue_item(blank(OP_NONE));
        for (int i = 0; i < 62; i++) queue_item(add_box(i, i, 0));
        queue_item(add_box(0, 0, 1));        // store full
        queue_item(query(0, 0, 200));        // many matches
        drain();

        write_reg(CFG_CELL_SIZE, 0);
        write_reg(CFG_MAX_CELLS, 1);
        queue_item(query(0, 0, 0));
        queue_item(query(0, 0, 1));
        drain();
        write_reg(CFG_MAX_CELLS, 0);
        queue_item(query(0, 0, 0));
        drain();
        write_reg(CFG_CELL_SIZE, 31'h7fff_ffff);
        write_reg(CFG_MAX_CELLS, 20'hfffff);
        queue_item(query(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        queue_item(blank(OP_CLEAR));
        drain();

        // back-pressure: fill the block while the receiver holds off
        write_reg(CFG_CELL_SIZE, 65536);
        write_reg(CFG_MAX_CELLS, 1000000);
        -> hold_go;
        for (int i = 0; i < 10; i++) queue_item(random_item());
        wait (hold_off);
        wait (!hold_off);
        drain();

        // random phases with varied configuration
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = pct_s[ph];
            receiver_stall_pct = pct_r[ph];
            write_reg(CFG_CELL_SIZE, (ph == 1) ? 1 : (ph == 2) ? 4096 : 65536);
            write_reg(CFG_MAX_CELLS, (ph == 1) ? 1000000 : (ph == 2) ? 5000 : 40);
            queue_item(blank(OP_CLEAR));
            for (int i = 0; i < 90; i++) queue_item(random_item());
            drain();
        end

        $display("Ran directed extremes, store overflow, back-pressure and four");
        $display("idling phases: %0d results, %0d point matches", answers_seen,
                 matches_seen);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
